// File: rtl/rfr_pkg.sv
// shared types, constants and crc helper for the register frame receiver
// no dependencies; used by every module in rtl/
`timescale 1ns / 1ps

package rfr_pkg;

  // store address width default and queue depths
  localparam int ADDR_BITS_DEF = 12;
  localparam int IN_Q_DEPTH    = 2;
  localparam int OUT_Q_DEPTH   = 4;

  // frame constants
  localparam logic [7:0]  SYNC_HI      = 8'hAB;
  localparam logic [7:0]  SYNC_LO      = 8'hCD;
  localparam logic [1:0]  FAULT_RELOAD = 2'd3;
  localparam logic [15:0] CRC_MSB      = 16'h8000;

  // input commands
  localparam logic [1:0] CMD_RX_BYTE  = 2'd0;
  localparam logic [1:0] CMD_SERVICE  = 2'd1;
  localparam logic [1:0] CMD_LOCAL_WR = 2'd2;
  localparam logic [1:0] CMD_TICK     = 2'd3;

  // frame status codes
  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_ACCEPT   = 2'd1;
  localparam logic [1:0] ST_CRC_ERR  = 2'd2;
  localparam logic [1:0] ST_DROPPED  = 2'd3;

  // configuration register indexes
  localparam int         CFG_IDX_W    = 3;
  localparam logic [2:0] CFG_POLY     = 3'd0;
  localparam logic [2:0] CFG_SEND     = 3'd1;
  localparam logic [2:0] CFG_REQUEST  = 3'd2;
  localparam logic [2:0] CFG_QUERY    = 3'd3;
  localparam logic [2:0] CFG_RESPONSE = 3'd4;

  // configuration reset values
  localparam logic [15:0] POLY_RST     = 16'h1021;
  localparam logic [7:0]  SEND_RST     = 8'd1;
  localparam logic [7:0]  REQUEST_RST  = 8'd2;
  localparam logic [7:0]  QUERY_RST    = 8'd3;
  localparam logic [7:0]  RESPONSE_RST = 8'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  rx_byte;
    logic [11:0] local_addr;
    logic [15:0] local_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       last;
    logic [1:0] frame_status;
    logic       peer_kind;
    logic       fault_flag;
  } out_item_t;

  // classified word handed from the front queue to the executor
  typedef struct packed {
    logic        is_rx;
    logic        is_service;
    logic        is_local_wr;
    logic        is_tick;
    logic [7:0]  rx_byte;
    logic [15:0] addr;
    logic [15:0] value;
    logic        addr_ok;
  } work_t;

  // one byte of msb-first crc-16
  function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                             input logic [7:0]  b,
                                             input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'd0) begin
        c = (c << 1) ^ poly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  // byte idx of an answer frame
  function automatic logic [7:0] ans_byte(input logic [3:0]  idx,
                                          input logic [7:0]  ftype,
                                          input logic [15:0] addr,
                                          input logic [15:0] data,
                                          input logic [15:0] crc);
    logic [7:0] b;
    case (idx)
      4'd0: b = SYNC_HI;
      4'd1: b = SYNC_LO;
      4'd2: b = ftype;
      4'd3: b = addr[15:8];
      4'd4: b = addr[7:0];
      4'd5: b = data[15:8];
      4'd6: b = data[7:0];
      4'd7: b = crc[15:8];
      4'd8: b = crc[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/register_frame_receiver_crc16_top.sv
// top level of the serial register access frame receiver with crc-16
// depends on rfr_pkg, rfr_front, rfr_back, rfr_out_q
`timescale 1ns / 1ps

// channel   handshake           payload                     word
// in_       in_push / in_full   rfr_pkg::in_item_t          command, byte or local write
// out_      out_pop / out_empty rfr_pkg::out_item_t         one result (answer byte or status)
// cfg_      cfg_valid/cfg_ready cfg_index [2:0], cfg_data   one config register write
//
// a byte or command that finishes no frame is handled in S_IDLE, one word a cycle while the result queue has room
// a closing crc byte is taken, then the header crc is checked (S_CHECK) and the frame decided (S_DECIDE);
//   an answer then takes a store read (request only), the answer crc (S_TXCRC) and the emit (S_EMIT)
// after reset all 2**ADDR_BITS store words are cleared; in_full stays high meanwhile
// a full result queue stalls the sequencer; the input queue keeps taking words until full
// cfg_ready is always high; config is to be written only while the block is idle, the block does not enforce it

module register_frame_receiver_crc16_top #(
  parameter int ADDR_BITS = rfr_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input word channel
  input  logic                           in_push,
  input  rfr_pkg::in_item_t              in_item,
  output logic                           in_full,
  // result word channel
  output logic                           out_empty,
  input  logic                           out_pop,
  output rfr_pkg::out_item_t             out_item,
  // config write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data
);

  logic               front_full;
  logic               front_push;
  logic               work_valid;
  rfr_pkg::work_t     work;
  logic               work_pop;
  logic               res_push;
  rfr_pkg::out_item_t res;
  logic               res_full;
  logic               clearing;

  // no words taken while the store clear runs
  assign in_full    = front_full || clearing;
  assign front_push = in_push && !in_full;
  assign cfg_ready  = 1'b1;

  // front: queue and classify incoming words
  rfr_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (front_push),
    .item       (in_item),
    .full       (front_full),
    .head_valid (work_valid),
    .head       (work),
    .pop        (work_pop)
  );

  // back: frame sequencer, crc, store, config
  rfr_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .work_valid (work_valid),
    .work       (work),
    .work_pop   (work_pop),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full),
    .clearing   (clearing)
  );

  // results wait here until popped
  rfr_out_q u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .item  (res),
    .full  (res_full),
    .empty (out_empty),
    .pop   (out_pop),
    .head  (out_item)
  );

endmodule

// File: rtl/rfr_front.sv
// front part: input word queue and command classification
// depends on rfr_pkg
`timescale 1ns / 1ps

module rfr_front #(
  parameter int ADDR_BITS = rfr_pkg::ADDR_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rfr_pkg::in_item_t item,
  output logic             full,
  output logic             head_valid,
  output rfr_pkg::work_t   head,
  input  logic             pop
);

  localparam int DEPTH = rfr_pkg::IN_Q_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rfr_pkg::in_item_t q_r [DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;
  rfr_pkg::in_item_t h;
  logic [15:0]       laddr;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wptr_r] <= item;
    end
  end

  // classify the oldest word
  assign h     = q_r[rptr_r];
  assign laddr = {4'b0000, h.local_addr};

  always_comb begin
    head             = '0;
    head.rx_byte     = h.rx_byte;
    head.addr        = laddr;
    head.value       = h.local_value;
    head.addr_ok     = ((laddr >> ADDR_BITS) == 16'd0);
    case (h.command)
      rfr_pkg::CMD_RX_BYTE:  head.is_rx       = 1'b1;
      rfr_pkg::CMD_SERVICE:  head.is_service  = 1'b1;
      rfr_pkg::CMD_LOCAL_WR: head.is_local_wr = 1'b1;
      rfr_pkg::CMD_TICK:     head.is_tick     = 1'b1;
      default:               head.is_tick     = 1'b1;
    endcase
  end

endmodule

// File: rtl/rfr_back.sv
// back part: frame sequencer, crc unit, register store and config registers
// depends on rfr_pkg
`timescale 1ns / 1ps

module rfr_back #(
  parameter int ADDR_BITS = rfr_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_data,
  input  logic                            work_valid,
  input  rfr_pkg::work_t                  work,
  output logic                            work_pop,
  output logic                            res_push,
  output rfr_pkg::out_item_t              res,
  input  logic                            res_full,
  output logic                            clearing
);

  localparam int STORE_DEPTH = 1 << ADDR_BITS;

  localparam logic [3:0] POS_SYNC_HI = 4'd0;
  localparam logic [3:0] POS_SYNC_LO = 4'd1;
  localparam logic [3:0] POS_CRC_LO  = 4'd8;
  localparam logic [3:0] IDX_HDR_END = 4'd6;
  localparam logic [3:0] IDX_FRM_END = 4'd8;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_RDWAIT = 7'b0010000,
    S_TXCRC  = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [3:0]             rx_pos_r, rx_pos_nxt;
  logic [7:0]             fb_r [8];
  logic [7:0]             fb_nxt [8];
  logic                   busy_r, busy_nxt;
  logic                   peer_r, peer_nxt;
  logic [1:0]             fcnt_r, fcnt_nxt;
  logic                   fstate_r, fstate_nxt;
  logic [15:0]            crc_r, crc_nxt;
  logic [3:0]             idx_r, idx_nxt;
  logic [7:0]             crc_lo_r, crc_lo_nxt;
  logic [7:0]             ans_type_r, ans_type_nxt;
  logic [15:0]            ans_addr_r, ans_addr_nxt;
  logic [15:0]            ans_data_r, ans_data_nxt;
  logic                   ans_ok_r, ans_ok_nxt;
  logic [ADDR_BITS-1:0]   clr_r, clr_nxt;

  logic [15:0]            poly_r;
  logic [7:0]             code_send_r, code_request_r, code_query_r, code_response_r;

  logic [15:0]            store_m [STORE_DEPTH];
  logic                   mem_we, mem_re;
  logic [ADDR_BITS-1:0]   mem_waddr, mem_raddr;
  logic [15:0]            mem_wdata, rd_q;

  logic [15:0]            f_addr, f_data;
  logic                   f_ok;
  logic [7:0]             cur_ans;
  logic [1:0]             res_status;
  logic [7:0]             res_txb;
  logic                   res_txv, res_last;

  assign f_addr   = {fb_r[3], fb_r[4]};
  assign f_data   = {fb_r[5], fb_r[6]};
  assign f_ok     = ((f_addr >> ADDR_BITS) == 16'd0);
  assign cur_ans  = rfr_pkg::ans_byte(idx_r, ans_type_r, ans_addr_r, ans_data_r, crc_r);
  assign clearing = (state_r == S_CLEAR);

  always_comb begin
    state_nxt    = state_r;
    rx_pos_nxt   = rx_pos_r;
    fb_nxt       = fb_r;
    busy_nxt     = busy_r;
    peer_nxt     = peer_r;
    fcnt_nxt     = fcnt_r;
    fstate_nxt   = fstate_r;
    crc_nxt      = crc_r;
    idx_nxt      = idx_r;
    crc_lo_nxt   = crc_lo_r;
    ans_type_nxt = ans_type_r;
    ans_addr_nxt = ans_addr_r;
    ans_data_nxt = ans_data_r;
    ans_ok_nxt   = ans_ok_r;
    clr_nxt      = clr_r;
    mem_we       = 1'b0;
    mem_waddr    = work.addr[ADDR_BITS-1:0];
    mem_wdata    = work.value;
    mem_re       = 1'b0;
    mem_raddr    = f_addr[ADDR_BITS-1:0];
    work_pop     = 1'b0;
    res_push     = 1'b0;
    res_status   = rfr_pkg::ST_NONE;
    res_txb      = 8'h00;
    res_txv      = 1'b0;
    res_last     = 1'b1;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = 16'h0000;
        clr_nxt   = clr_r + {{(ADDR_BITS-1){1'b0}}, 1'b1};
        if (clr_r == {ADDR_BITS{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (work_valid && !res_full) begin
          work_pop = 1'b1;
          if (work.is_rx) begin
            if (busy_r) begin
              rx_pos_nxt = POS_SYNC_HI;
              res_push   = 1'b1;
              res_status = rfr_pkg::ST_DROPPED;
            end else if (rx_pos_r == POS_CRC_LO) begin
              crc_lo_nxt = work.rx_byte;
              rx_pos_nxt = POS_SYNC_HI;
              crc_nxt    = 16'h0000;
              idx_nxt    = 4'd0;
              state_nxt  = S_CHECK;
            end else begin
              res_push = 1'b1;
              if (rx_pos_r == POS_SYNC_HI) begin
                if (work.rx_byte == rfr_pkg::SYNC_HI) begin
                  fb_nxt[0]  = work.rx_byte;
                  rx_pos_nxt = POS_SYNC_LO;
                end
              end else if (rx_pos_r == POS_SYNC_LO) begin
                if (work.rx_byte == rfr_pkg::SYNC_LO) begin
                  fb_nxt[1]  = work.rx_byte;
                  rx_pos_nxt = 4'd2;
                end else begin
                  rx_pos_nxt = POS_SYNC_HI;
                end
              end else begin
                fb_nxt[rx_pos_r[2:0]] = work.rx_byte;
                rx_pos_nxt            = rx_pos_r + 4'd1;
              end
            end
          end else if (work.is_service) begin
            busy_nxt = 1'b0;
            res_push = 1'b1;
          end else if (work.is_local_wr) begin
            mem_we   = work.addr_ok;
            res_push = 1'b1;
          end else if (work.is_tick) begin
            if (fcnt_r == 2'd0) begin
              fstate_nxt = 1'b1;
            end else begin
              fcnt_nxt   = fcnt_r - 2'd1;
              fstate_nxt = 1'b0;
            end
            res_push = 1'b1;
          end
        end
      end

      // crc over the seven received header bytes, one byte a cycle
      S_CHECK: begin
        crc_nxt = rfr_pkg::crc_update(crc_r, fb_r[idx_r[2:0]], poly_r);
        idx_nxt = idx_r + 4'd1;
        if (idx_r == IDX_HDR_END) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (!res_full) begin
          if (fb_r[7] != crc_r[15:8] || crc_lo_r != crc_r[7:0]) begin
            res_push   = 1'b1;
            res_status = rfr_pkg::ST_CRC_ERR;
            state_nxt  = S_IDLE;
          end else begin
            busy_nxt     = 1'b1;
            ans_addr_nxt = f_addr;
            crc_nxt      = 16'h0000;
            idx_nxt      = 4'd0;
            if (fb_r[2] == code_send_r) begin
              ans_type_nxt = code_response_r;
              ans_data_nxt = f_data;
              mem_we       = f_ok;
              mem_waddr    = f_addr[ADDR_BITS-1:0];
              mem_wdata    = f_data;
              state_nxt    = S_TXCRC;
            end else if (fb_r[2] == code_request_r) begin
              ans_type_nxt = code_send_r;
              ans_ok_nxt   = f_ok;
              mem_re       = 1'b1;
              state_nxt    = S_RDWAIT;
            end else begin
              if (fb_r[2] == code_query_r) begin
                fcnt_nxt = rfr_pkg::FAULT_RELOAD;
                peer_nxt = (f_data == 16'd1);
              end
              res_push   = 1'b1;
              res_status = rfr_pkg::ST_ACCEPT;
              state_nxt  = S_IDLE;
            end
          end
        end
      end

      S_RDWAIT: begin
        ans_data_nxt = ans_ok_r ? rd_q : 16'h0000;
        state_nxt    = S_TXCRC;
      end

      // crc over the seven answer header bytes
      S_TXCRC: begin
        crc_nxt = rfr_pkg::crc_update(crc_r, cur_ans, poly_r);
        idx_nxt = idx_r + 4'd1;
        if (idx_r == IDX_HDR_END) begin
          idx_nxt   = 4'd0;
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          res_status = rfr_pkg::ST_ACCEPT;
          res_txb    = cur_ans;
          res_txv    = 1'b1;
          res_last   = (idx_r == IDX_FRM_END);
          idx_nxt    = idx_r + 4'd1;
          if (idx_r == IDX_FRM_END) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res = '{tx_byte:      res_txb,
                 tx_valid:     res_txv,
                 last:         res_last,
                 frame_status: res_status,
                 peer_kind:    peer_nxt,
                 fault_flag:   fstate_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      rx_pos_r <= POS_SYNC_HI;
      busy_r   <= 1'b0;
      peer_r   <= 1'b0;
      fcnt_r   <= rfr_pkg::FAULT_RELOAD;
      fstate_r <= 1'b0;
      idx_r    <= 4'd0;
      clr_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      rx_pos_r <= rx_pos_nxt;
      busy_r   <= busy_nxt;
      peer_r   <= peer_nxt;
      fcnt_r   <= fcnt_nxt;
      fstate_r <= fstate_nxt;
      idx_r    <= idx_nxt;
      clr_r    <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fb_r       <= fb_nxt;
    crc_r      <= crc_nxt;
    crc_lo_r   <= crc_lo_nxt;
    ans_type_r <= ans_type_nxt;
    ans_addr_r <= ans_addr_nxt;
    ans_data_r <= ans_data_nxt;
    ans_ok_r   <= ans_ok_nxt;
  end

  // config registers, index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r          <= rfr_pkg::POLY_RST;
      code_send_r     <= rfr_pkg::SEND_RST;
      code_request_r  <= rfr_pkg::REQUEST_RST;
      code_query_r    <= rfr_pkg::QUERY_RST;
      code_response_r <= rfr_pkg::RESPONSE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rfr_pkg::CFG_POLY:     poly_r          <= cfg_data;
        rfr_pkg::CFG_SEND:     code_send_r     <= cfg_data[7:0];
        rfr_pkg::CFG_REQUEST:  code_request_r  <= cfg_data[7:0];
        rfr_pkg::CFG_QUERY:    code_query_r    <= cfg_data[7:0];
        rfr_pkg::CFG_RESPONSE: code_response_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // register store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_m[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= store_m[mem_raddr];
    end
  end

endmodule

// File: rtl/rfr_out_q.sv
// result queue between the sequencer and the output port
// depends on rfr_pkg
`timescale 1ns / 1ps

module rfr_out_q (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rfr_pkg::out_item_t item,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output rfr_pkg::out_item_t head
);

  localparam int DEPTH = rfr_pkg::OUT_Q_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rfr_pkg::out_item_t q_r [DEPTH];
  logic [PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = q_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wptr_r] <= item;
    end
  end

endmodule

// File: verif/register_frame_receiver_crc16_top_test.sv
// self-checking test of register_frame_receiver_crc16_top: directed frames, then random traffic
// under several crc and type code settings, checked against a behavioral frame receiver model
// depends on rfr_pkg and the rtl under rtl/
`timescale 1ns / 1ps

module register_frame_receiver_crc16_top_test;

  localparam int STORE_BITS   = rfr_pkg::ADDR_BITS_DEF;
  localparam int IDX_W        = rfr_pkg::CFG_IDX_W;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 12000;  // covers the store clear after reset

  // receiver pop patterns
  localparam int POP_ALWAYS   = 0;
  localparam int POP_HALF     = 1;
  localparam int POP_SPARSE   = 2;
  localparam int POP_PERIODIC = 3;

  // a type code that the reset settings do not use
  localparam logic [7:0] UNKNOWN_TYPE = 8'hEE;

  typedef logic [0:8][7:0] frame_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_push   = 1'b0;
  rfr_pkg::in_item_t     in_item   = '0;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_pop   = 1'b0;
  rfr_pkg::out_item_t    out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [15:0]           cfg_data  = '0;

  register_frame_receiver_crc16_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // model copy of the config registers
  logic [15:0] reg_poly;
  logic [7:0]  reg_send, reg_request, reg_query, reg_response;

  // model copy of the receiver state
  logic [3:0]  rx_pos;
  logic [7:0]  rx_frame [0:7];
  logic        rx_busy;
  logic [15:0] store_mirror [0:(1 << STORE_BITS) - 1];
  logic        peer_type;
  logic [1:0]  fault_count;
  logic        fault_state;

  // result words still owed by the block, oldest first
  rfr_pkg::out_item_t due_out_words [$];

  int                 mismatches = 0;
  int                 items_sent = 0;
  int                 burst_left = 0;
  int                 idle_cycles = 0;
  int                 rx_mode = POP_ALWAYS;
  int                 rx_tick = 0;
  rfr_pkg::out_item_t want;

  task automatic model_reset();
    reg_poly     = rfr_pkg::POLY_RST;
    reg_send     = rfr_pkg::SEND_RST;
    reg_request  = rfr_pkg::REQUEST_RST;
    reg_query    = rfr_pkg::QUERY_RST;
    reg_response = rfr_pkg::RESPONSE_RST;
    rx_pos       = 4'd0;
    rx_busy      = 1'b0;
    peer_type    = 1'b0;
    fault_count  = rfr_pkg::FAULT_RELOAD;
    fault_state  = 1'b0;
    for (int i = 0; i < 8; i++) rx_frame[i] = 8'h00;
    for (int i = 0; i < (1 << STORE_BITS); i++) store_mirror[i] = 16'h0000;
  endtask

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ reg_poly) : (c << 1);
    end
    return c;
  endfunction

  // full 9-byte frame with crc over the first seven bytes, high crc byte first
  function automatic frame_t make_frame(input logic [7:0] ftype, input logic [15:0] addr,
                                        input logic [15:0] data);
    frame_t      f;
    logic [15:0] crc;
    f[0] = rfr_pkg::SYNC_HI;
    f[1] = rfr_pkg::SYNC_LO;
    f[2] = ftype;
    f[3] = addr[15:8];
    f[4] = addr[7:0];
    f[5] = data[15:8];
    f[6] = data[7:0];
    crc = 16'h0000;
    for (int i = 0; i < 7; i++) crc = crc16_byte(crc, f[i]);
    f[7] = crc[15:8];
    f[8] = crc[7:0];
    return f;
  endfunction

  function automatic bit in_store(input logic [15:0] addr);
    return (addr >> STORE_BITS) == 16'd0;
  endfunction

  function automatic rfr_pkg::out_item_t status_word(input logic [7:0] b, input logic valid,
                                                     input logic fin, input logic [1:0] st);
    rfr_pkg::out_item_t w;
    w.tx_byte      = b;
    w.tx_valid     = valid;
    w.last         = fin;
    w.frame_status = st;
    w.peer_kind    = peer_type;
    w.fault_flag   = fault_state;
    return w;
  endfunction

  task automatic queue_answer(input logic [7:0] ftype, input logic [15:0] addr,
                              input logic [15:0] data);
    frame_t f;
    f = make_frame(ftype, addr, data);
    for (int i = 0; i < 9; i++) begin
      due_out_words.push_back(status_word(f[i], 1'b1, i == 8, rfr_pkg::ST_ACCEPT));
    end
  endtask

  // closing crc byte: check the frame, then act on its type
  task automatic close_frame(input logic [7:0] crc_lo);
    frame_t      got;
    frame_t      good;
    logic [15:0] addr;
    logic [15:0] data;
    for (int i = 0; i < 8; i++) got[i] = rx_frame[i];
    got[8] = crc_lo;
    addr   = {got[3], got[4]};
    data   = {got[5], got[6]};
    good   = make_frame(got[2], addr, data);
    rx_pos = 4'd0;
    if ({good[7], good[8]} != {got[7], got[8]}) begin
      due_out_words.push_back(status_word(8'h00, 1'b0, 1'b1, rfr_pkg::ST_CRC_ERR));
    end else begin
      rx_busy = 1'b1;
      if (got[2] == reg_send) begin
        if (in_store(addr)) store_mirror[addr[STORE_BITS-1:0]] = data;
        queue_answer(reg_response, addr, data);
      end else if (got[2] == reg_request) begin
        queue_answer(reg_send, addr,
                     in_store(addr) ? store_mirror[addr[STORE_BITS-1:0]] : 16'h0000);
      end else begin
        if (got[2] == reg_query) begin
          fault_count = rfr_pkg::FAULT_RELOAD;
          peer_type   = (data == 16'd1);
        end
        due_out_words.push_back(status_word(8'h00, 1'b0, 1'b1, rfr_pkg::ST_ACCEPT));
      end
    end
  endtask

  task automatic take_rx_byte(input logic [7:0] b);
    if (rx_busy) begin
      rx_pos = 4'd0;
      due_out_words.push_back(status_word(8'h00, 1'b0, 1'b1, rfr_pkg::ST_DROPPED));
    end else if (rx_pos == 4'd8) begin
      close_frame(b);
    end else begin
      if (rx_pos == 4'd0) begin
        if (b == rfr_pkg::SYNC_HI) begin
          rx_frame[0] = b;
          rx_pos = 4'd1;
        end
      end else if (rx_pos == 4'd1) begin
        if (b == rfr_pkg::SYNC_LO) begin
          rx_frame[1] = b;
          rx_pos = 4'd2;
        end else begin
          rx_pos = 4'd0;
        end
      end else begin
        rx_frame[rx_pos[2:0]] = b;
        rx_pos = rx_pos + 4'd1;
      end
      due_out_words.push_back(status_word(8'h00, 1'b0, 1'b1, rfr_pkg::ST_NONE));
    end
  endtask

  // predicts the result words of one accepted input word
  task automatic model_take_word(input rfr_pkg::in_item_t w);
    if (w.command == rfr_pkg::CMD_RX_BYTE) begin
      take_rx_byte(w.rx_byte);
    end else begin
      case (w.command)
        rfr_pkg::CMD_SERVICE: begin
          rx_busy = 1'b0;
        end
        rfr_pkg::CMD_LOCAL_WR: begin
          if (in_store({4'h0, w.local_addr})) begin
            store_mirror[w.local_addr[STORE_BITS-1:0]] = w.local_value;
          end
        end
        default: begin
          if (fault_count == 2'd0) begin
            fault_state = 1'b1;
          end else begin
            fault_count = fault_count - 2'd1;
            fault_state = 1'b0;
          end
        end
      endcase
      due_out_words.push_back(status_word(8'h00, 1'b0, 1'b1, rfr_pkg::ST_NONE));
    end
  endtask

  // sender: bursts of random length, random gaps between them
  task automatic push_word(input rfr_pkg::in_item_t w);
    int gap;
    if (burst_left == 0) begin
      in_push <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    in_push <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (in_full !== 1'b0);
    model_take_word(w);
    items_sent++;
    burst_left--;
  endtask

  // unused fields carry random bits
  function automatic rfr_pkg::in_item_t noise_item(input logic [1:0] cmd);
    rfr_pkg::in_item_t w;
    w.command     = cmd;
    w.rx_byte     = 8'($urandom_range(0, 255));
    w.local_addr  = 12'($urandom_range(0, 4095));
    w.local_value = 16'($urandom_range(0, 65535));
    return w;
  endfunction

  task automatic send_cmd(input logic [1:0] cmd);
    push_word(noise_item(cmd));
  endtask

  task automatic send_rx_byte(input logic [7:0] b);
    rfr_pkg::in_item_t w;
    w = noise_item(rfr_pkg::CMD_RX_BYTE);
    w.rx_byte = b;
    push_word(w);
  endtask

  task automatic local_write(input logic [11:0] addr, input logic [15:0] value);
    rfr_pkg::in_item_t w;
    w = noise_item(rfr_pkg::CMD_LOCAL_WR);
    w.local_addr  = addr;
    w.local_value = value;
    push_word(w);
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] addr,
                            input logic [15:0] data, input bit corrupt);
    frame_t f;
    int     k;
    f = make_frame(ftype, addr, data);
    if (corrupt) begin
      k = $urandom_range(7, 8);
      f[k] = f[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (int i = 0; i < 9; i++) send_rx_byte(f[i]);
  endtask

  // mostly the low store words so reads hit earlier writes, some near the top and beyond
  function automatic logic [15:0] pick_addr();
    logic [15:0] a;
    int          r;
    r = $urandom_range(0, 99);
    a = 16'($urandom_range(0, 65535));
    if (r < 55) begin
      a = {13'd0, a[2:0]};
    end else if (r < 70) begin
      a = {4'h0, 9'h1FF, a[2:0]};
    end else if (r < 88) begin
      a[15:12] = 4'h0;
    end else if (a[15:12] == 4'h0) begin
      a[15] = 1'b1;
    end
    return a;
  endfunction

  task automatic wait_idle();
    in_push <= 1'b0;
    burst_left = 0;
    while (due_out_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // valid stays high across back-to-back writes
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      rfr_pkg::CFG_POLY:     reg_poly     = value;
      rfr_pkg::CFG_SEND:     reg_send     = value[7:0];
      rfr_pkg::CFG_REQUEST:  reg_request  = value[7:0];
      rfr_pkg::CFG_QUERY:    reg_query    = value[7:0];
      rfr_pkg::CFG_RESPONSE: reg_response = value[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] poly, input logic [7:0] send,
                               input logic [7:0] request, input logic [7:0] query,
                               input logic [7:0] response);
    logic [IDX_W-1:0] spare;
    logic [7:0]       hi;
    wait_idle();
    hi = 8'($urandom_range(0, 255));
    write_reg(rfr_pkg::CFG_POLY, poly);
    write_reg(rfr_pkg::CFG_SEND, {hi, send});
    write_reg(rfr_pkg::CFG_REQUEST, {~hi, request});
    write_reg(rfr_pkg::CFG_QUERY, {hi ^ 8'h5A, query});
    write_reg(rfr_pkg::CFG_RESPONSE, {8'hFF, response});
    // index past the register set, must be ignored
    spare = IDX_W'($urandom_range(rfr_pkg::CFG_RESPONSE + 1, (1 << IDX_W) - 1));
    write_reg(spare, 16'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_answer_frames();
    send_frame(reg_request, 16'h0000, 16'hFFFF, 0);  // cleared store reads zero
    send_cmd(rfr_pkg::CMD_SERVICE);
    send_frame(reg_send, 16'h0FFF, 16'hFFFF, 0);     // top store word
    send_cmd(rfr_pkg::CMD_SERVICE);
    send_frame(reg_send, 16'hFFFF, 16'h1234, 0);     // beyond the store: echoed, not written
    send_cmd(rfr_pkg::CMD_SERVICE);
    send_frame(reg_request, 16'h1000, 16'h0000, 0);  // beyond the store reads zero
    send_cmd(rfr_pkg::CMD_SERVICE);
    local_write(12'h000, 16'hA5A5);
    send_frame(reg_request, 16'h0000, 16'h0000, 0);
    send_cmd(rfr_pkg::CMD_SERVICE);
  endtask

  task automatic test_frame_errors();
    send_rx_byte(rfr_pkg::SYNC_HI);
    send_rx_byte(8'h00);                             // bad second sync
    send_rx_byte(rfr_pkg::SYNC_LO);                  // not taken as a first sync
    send_rx_byte(rfr_pkg::SYNC_HI);
    send_rx_byte(rfr_pkg::SYNC_HI);                  // bad second sync, hunt restarts
    send_frame(reg_send, 16'h0001, 16'h5A5A, 1);     // crc error
    send_frame(reg_query, 16'h0000, 16'h0001, 0);    // peer type 1
    send_rx_byte(rfr_pkg::SYNC_HI);                  // dropped while busy
    send_rx_byte(8'hFF);
    send_cmd(rfr_pkg::CMD_SERVICE);
    send_cmd(rfr_pkg::CMD_SERVICE);                  // service with receiver already free
    send_frame(UNKNOWN_TYPE, 16'h0002, 16'h0003, 0); // accepted, no answer
    send_cmd(rfr_pkg::CMD_SERVICE);
  endtask

  task automatic test_fault_counter();
    repeat (5) send_cmd(rfr_pkg::CMD_TICK);          // counts down, then raises the flag
    send_frame(reg_query, 16'hFFFF, 16'h0000, 0);    // reloads, flag held, peer type back to 0
    send_cmd(rfr_pkg::CMD_SERVICE);
    send_cmd(rfr_pkg::CMD_TICK);                     // clears the flag
  endtask

  task automatic test_random_traffic(input int n);
    int          start;
    int          pick;
    int          k;
    logic [7:0]  ftype;
    logic [15:0] data;
    frame_t      f;
    start = items_sent;
    while (items_sent < start + n) begin
      pick = $urandom_range(0, 99);
      data = ($urandom_range(0, 3) == 0) ? 16'd1 : 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 3))
        0:       ftype = reg_send;
        1:       ftype = reg_request;
        2:       ftype = reg_query;
        default: ftype = 8'($urandom_range(0, 255));
      endcase
      if (pick < 65) begin
        send_frame(ftype, pick_addr(), data, $urandom_range(0, 6) == 0);
        if (rx_busy) begin
          repeat ($urandom_range(0, 2)) send_rx_byte(8'($urandom_range(0, 255)));
          send_cmd(rfr_pkg::CMD_SERVICE);
        end
      end else if (pick < 75) begin
        // frame cut short, the next bytes run into it
        f = make_frame(ftype, pick_addr(), data);
        k = $urandom_range(1, 8);
        for (int i = 0; i < k; i++) send_rx_byte(f[i]);
      end else if (pick < 83) begin
        repeat ($urandom_range(1, 3)) send_rx_byte(8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        local_write(12'(pick_addr()), 16'($urandom_range(0, 65535)));
      end else if (pick < 96) begin
        send_cmd(rfr_pkg::CMD_TICK);
      end else begin
        send_cmd(rfr_pkg::CMD_SERVICE);
      end
    end
  endtask

  task automatic test_config_sweep();
    apply_setting(16'hFFFF, 8'h00, 8'hFF, 8'h7F, 8'hFF);
    test_random_traffic(3);
    apply_setting(16'h0000, 8'hFF, 8'h80, 8'h00, 8'h00);
    test_random_traffic(3);
    apply_setting(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'hFF, 8'($urandom_range(0, 255)));
    test_random_traffic(3);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // result side: check each popped word, then pick the next pop
  always @(posedge clk) begin
    if (rst_n && out_pop && out_empty === 1'b0) begin
      if (due_out_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_item);
        mismatches++;
      end else begin
        want = due_out_words.pop_front();
        check_field("tx_byte", want.tx_byte, out_item.tx_byte);
        check_field("tx_valid", 8'(want.tx_valid), 8'(out_item.tx_valid));
        check_field("last", 8'(want.last), 8'(out_item.last));
        check_field("frame_status", 8'(want.frame_status), 8'(out_item.frame_status));
        check_field("peer_kind", 8'(want.peer_kind), 8'(out_item.peer_kind));
        check_field("fault_flag", 8'(want.fault_flag), 8'(out_item.fault_flag));
      end
    end
    rx_tick++;
    if (rx_tick % 48 == 0) rx_mode = $urandom_range(POP_ALWAYS, POP_PERIODIC);
    case (rx_mode)
      POP_ALWAYS: out_pop <= 1'b1;
      POP_HALF:   out_pop <= 1'($urandom_range(0, 1));
      POP_SPARSE: out_pop <= ($urandom_range(0, 3) == 0);
      default:    out_pop <= (rx_tick % 5) < 3;
    endcase
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_push && in_full === 1'b0) || (out_pop && out_empty === 1'b0) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_answer_frames();
    test_frame_errors();
    test_fault_counter();
    test_config_sweep();
    wait_idle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: register_frame_receiver_crc16_top.f
rtl/rfr_pkg.sv
rtl/rfr_front.sv
rtl/rfr_back.sv
rtl/rfr_out_q.sv
rtl/register_frame_receiver_crc16_top.sv
verif/register_frame_receiver_crc16_top_test.sv
